### design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PPU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ppu_pkg.sv
// Shared constants and types of the packed pixel unpacker.
`default_nettype none

package ppu_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);
	localparam int PAL_CW      = 9;   // compare width, holds entry count and index + 1
	localparam int PAL_WIDTH   = 24;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 8;

	localparam logic [CFG_IW-1:0] REG_RED_W  = 3'd0;
	localparam logic [CFG_IW-1:0] REG_GRN_W  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_BLU_W  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_ALP_W  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_ORDER  = 3'd4;
	localparam logic [CFG_IW-1:0] REG_PAL_EN = 3'd5;

	localparam logic [3:0] RST_RGB_W  = 4'd8;
	localparam logic [5:0] RST_ALP_W  = 6'd8;
	localparam logic [7:0] RST_ORDER  = 8'd228;

	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_PALETTE = 1'b1;

	localparam logic [1:0] POS_0 = 2'd0;
	localparam logic [1:0] POS_1 = 2'd1;
	localparam logic [1:0] POS_2 = 2'd2;
	localparam logic [1:0] POS_3 = 2'd3;

	// Decoded format, one slot per color channel (red, green, blue).
	typedef struct packed {
		logic            ok;
		logic            alpha_only;
		logic [2:0][4:0] start;
		logic [2:0][3:0] wid;
		logic [2:0][1:0] pos;
	} fmt_t;

endpackage

`default_nettype wire

### design/packed_pixel_to_rgb888_unpacker.sv
// Packed pixel to RGB888 unpacker: top level.
//
// Input stream (s_axis_*): one item per pixel or palette write. tuser is the kind
// (0 convert a pixel, 1 write a palette entry). Output stream (m_axis_*): one item
// per pixel item, none for palette items; tdata holds red, green, blue and tuser
// holds format_ok (0 when the configured format is invalid, colors then zero).
// Configuration channel (cfg_*): register index and data, always ready; write it
// only while no pixel is in flight.
// An accepted pixel is registered in the read stage and then in the output register.
// Throughput: one item per clock unless the receiver stalls, set by the single read
// port of each palette RAM; the palette sits in two RAMs (full entry, and red alone
// read at index + 1) so both lookups of a pixel happen in the same cycle.
// A palette write is visible to a pixel item accepted in the next cycle.
// Reset clears the registers to their defaults and all palette valid bits, so the
// palette reads as zero with no clearing pass; items are taken right after reset.
// When the receiver stalls, the output register holds and one more item may
// enter the read stage; after that s_axis_tready drops.
`default_nettype none
`include "assert_macros.svh"

module packed_pixel_to_rgb888_unpacker
	import ppu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// raw_pixel[31:0], entry_index[39:32], entry_red[47:40], entry_green[55:48],
	// entry_blue[63:56]
	input  wire logic [63:0]       s_axis_tdata,
	// kind[0]
	input  wire logic              s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// red[7:0], green[15:8], blue[23:16]
	output logic      [23:0]       m_axis_tdata,
	// format_ok[0]
	output logic                   m_axis_tuser,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	// configuration registers
	logic [3:0] red_w_q, grn_w_q, blu_w_q;
	logic [5:0] alp_w_q;
	logic [7:0] order_q;
	logic       pal_en_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_w_q  <= RST_RGB_W;
			grn_w_q  <= RST_RGB_W;
			blu_w_q  <= RST_RGB_W;
			alp_w_q  <= RST_ALP_W;
			order_q  <= RST_ORDER;
			pal_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RED_W:  red_w_q  <= cfg_data[3:0];
				REG_GRN_W:  grn_w_q  <= cfg_data[3:0];
				REG_BLU_W:  blu_w_q  <= cfg_data[3:0];
				REG_ALP_W:  alp_w_q  <= cfg_data[5:0];
				REG_ORDER:  order_q  <= cfg_data[7:0];
				REG_PAL_EN: pal_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	fmt_t fmt;

	ppu_format u_format (
		.red_width    (red_w_q),
		.green_width  (grn_w_q),
		.blue_width   (blu_w_q),
		.alpha_width  (alp_w_q),
		.channel_order(order_q),
		.fmt          (fmt)
	);

	// input side
	logic              s_acc;
	logic              pix_acc;
	logic [31:0]       in_pix;
	logic [7:0]        in_entry;
	logic [PAL_CW-1:0] in_entry_c;
	logic [PAL_CW-1:0] idx_c;
	logic [PAL_CW-1:0] nxt_c;
	logic              pal_we;
	logic              s1_valid_q;
	logic              s1_adv;
	logic              out_valid_q;

	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign pix_acc       = s_acc && (s_axis_tuser == KIND_PIXEL);

	assign in_pix     = s_axis_tdata[31:0];
	assign in_entry   = s_axis_tdata[39:32];
	assign in_entry_c = {1'b0, in_entry};
	assign idx_c      = {1'b0, in_pix[7:0]};
	assign nxt_c      = idx_c + PAL_CW'(1);
	assign pal_we     = s_acc && (s_axis_tuser == KIND_PALETTE) &&
	                    (in_entry_c < PAL_CW'(PAL_ENTRIES));

	// palette: full entry at index, red alone read at index + 1
	logic [PAL_WIDTH-1:0] ent_rd;
	logic [7:0]           nxt_red_rd;

	ppu_ram #(.WIDTH(PAL_WIDTH), .DEPTH(PAL_ENTRIES)) u_pal_ram (
		.clk  (clk),
		.we   (pal_we),
		.waddr(in_entry_c[PAL_AW-1:0]),
		.wdata(s_axis_tdata[63:40]),
		.re   (pix_acc),
		.raddr(idx_c[PAL_AW-1:0]),
		.rdata(ent_rd)
	);

	ppu_ram #(.WIDTH(8), .DEPTH(PAL_ENTRIES)) u_nxt_ram (
		.clk  (clk),
		.we   (pal_we),
		.waddr(in_entry_c[PAL_AW-1:0]),
		.wdata(s_axis_tdata[47:40]),
		.re   (pix_acc),
		.raddr(nxt_c[PAL_AW-1:0]),
		.rdata(nxt_red_rd)
	);

	// entries never written since reset read as zero
	logic [PAL_ENTRIES-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pal_we) begin
			vld_q[in_entry_c[PAL_AW-1:0]] <= 1'b1;
		end
	end

	// read stage
	logic [31:0] pix_s1;
	logic        hit_s1;
	logic        nxt_hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= pix_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1     <= in_pix;
			hit_s1     <= (idx_c < PAL_CW'(PAL_ENTRIES)) && vld_q[idx_c[PAL_AW-1:0]];
			nxt_hit_s1 <= (nxt_c < PAL_CW'(PAL_ENTRIES)) && vld_q[nxt_c[PAL_AW-1:0]];
		end
	end

	logic [7:0]      ent_r, ent_g, ent_b, nxt_r;
	logic [2:0][7:0] col;
	logic [31:0]     fld;
	logic [7:0]      fld8;

	always_comb begin
		ent_r = hit_s1 ? ent_rd[7:0]   : 8'd0;
		ent_g = hit_s1 ? ent_rd[15:8]  : 8'd0;
		ent_b = hit_s1 ? ent_rd[23:16] : 8'd0;
		nxt_r = nxt_hit_s1 ? nxt_red_rd : 8'd0;
		fld   = '0;
		fld8  = '0;
		for (int i = 0; i < 3; i++) begin
			col[i] = 8'd0;
			if (!fmt.ok) begin
				col[i] = 8'd0;
			end else if (fmt.alpha_only && !pal_en_q) begin
				col[i] = pix_s1[7:0];
			end else if (fmt.alpha_only) begin
				unique case (fmt.pos[i])
					POS_0: col[i] = ent_r;
					POS_1: col[i] = ent_g;
					POS_2: col[i] = ent_b;
					POS_3: col[i] = nxt_r;
				endcase
			end else begin
				// field top bit lands at bit 7; zero width shifts everything out
				fld    = pix_s1 >> fmt.start[i];
				fld8   = fld[7:0];
				col[i] = fld8 << (4'd8 - fmt.wid[i]);
			end
		end
	end

	// output register
	logic [23:0] rgb_q;
	logic        ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			rgb_q <= {col[2], col[1], col[0]};
			ok_q  <= fmt.ok;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = rgb_q;
	assign m_axis_tuser  = ok_q;

	`PPU_ASSERT_NOW(a_bad_fmt_black, out_valid_q && !ok_q, rgb_q == '0, "color on bad format")
	`PPU_ASSERT_NEXT(a_pal_vld_set, pal_we, vld_q[$past(in_entry_c[PAL_AW-1:0])], "entry not valid")
	`PPU_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_adv, s1_valid_q, "read stage item dropped")
	`PPU_ASSERT_NEXT(a_out_fill, s1_valid_q && s1_adv, m_axis_tvalid, "item not moved to output")

endmodule

`default_nettype wire

### design/ppu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/ppu_format.sv
// Format decode: validity check and per-channel bit offsets.
`default_nettype none

module ppu_format
	import ppu_pkg::*;
(
	input  wire logic [3:0] red_width,
	input  wire logic [3:0] green_width,
	input  wire logic [3:0] blue_width,
	input  wire logic [5:0] alpha_width,
	input  wire logic [7:0] channel_order,
	output fmt_t            fmt
);

	logic [3:0][5:0] wid;
	logic [3:0][1:0] pos;
	logic [6:0]      total;
	logic [2:0][6:0] start;
	logic            pos_unique;
	logic            rgb_fit;

	always_comb begin
		wid[0] = {2'b00, red_width};
		wid[1] = {2'b00, green_width};
		wid[2] = {2'b00, blue_width};
		wid[3] = alpha_width;
		for (int i = 0; i < 4; i++) begin
			pos[i] = channel_order[2*i +: 2];
		end
		total = 7'(wid[0]) + 7'(wid[1]) + 7'(wid[2]) + 7'(wid[3]);

		// channel offset = widths of every channel packed below it
		for (int i = 0; i < 3; i++) begin
			start[i] = '0;
			for (int k = 0; k < 4; k++) begin
				if (k != i && pos[k] < pos[i]) begin
					start[i] = start[i] + 7'(wid[k]);
				end
			end
		end

		pos_unique = (pos[0] != pos[1]) && (pos[0] != pos[2]) && (pos[0] != pos[3]) &&
		             (pos[1] != pos[2]) && (pos[1] != pos[3]) && (pos[2] != pos[3]);
		rgb_fit = (red_width <= 4'd8) && (green_width <= 4'd8) && (blue_width <= 4'd8);

		fmt.ok = (total != 7'd0) && (total[2:0] == 3'd0) && (total <= 7'd32) &&
		         pos_unique && rgb_fit;
		fmt.alpha_only = (red_width == 4'd0) && (green_width == 4'd0) &&
		                 (blue_width == 4'd0);
		for (int i = 0; i < 3; i++) begin
			fmt.start[i] = start[i][4:0];
			fmt.wid[i]   = wid[i][3:0];
			fmt.pos[i]   = pos[i];
		end
	end

endmodule

`default_nettype wire
